@@ rtl/trsd_pkg.sv @@
// ----------------------------------------------------------------------------
// trsd_pkg
// Shared types and constants for the affine transform decomposition block.
// ----------------------------------------------------------------------------
package trsd_pkg;

  // rotation element in Q.30, wide enough for +-2^31
  localparam int ElemW  = 33;
  localparam int QDepth = 4;

  typedef logic signed [ElemW-1:0] elem_t;

  // one normalized matrix as handed from the front to the back
  typedef struct packed {
    elem_t [8:0]      e;
    logic [2:0][31:0] scale;
    logic [2:0][31:0] trans;
  } trsd_item_t;

endpackage

@@ rtl/trsd_pipe.sv @@
// ----------------------------------------------------------------------------
// trsd_pipe
// Delay line with a shared advance enable, keeps side data aligned with math.
// ----------------------------------------------------------------------------
module trsd_pipe #(
  parameter int W = 8,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] stg [N];

  always_ff @(posedge clk) begin
    if (en) begin
      stg[0] <= d;
      for (int i = 1; i < N; i++) begin
        stg[i] <= stg[i-1];
      end
    end
  end

  assign q = stg[N-1];

endmodule

@@ rtl/trsd_isqrt.sv @@
// ----------------------------------------------------------------------------
// trsd_isqrt
// Pipelined integer square root, one root bit per stage, floor result.
// ----------------------------------------------------------------------------
module trsd_isqrt #(
  parameter int NW = 64
) (
  input  logic            clk,
  input  logic            en,
  input  logic [NW-1:0]   rad,
  output logic [NW/2-1:0] root
);

  localparam int RW = NW / 2;

  logic [RW+1:0] rem_q  [RW];
  logic [RW-1:0] root_q [RW];
  logic [NW-1:0] rad_q  [RW];

  for (genvar j = 0; j < RW; j++) begin : g_stage
    logic [RW+1:0] rem_i;
    logic [RW+1:0] remx;
    logic [RW+1:0] trial;
    logic [RW-1:0] root_i;
    logic [NW-1:0] rad_i;
    logic          ge;

    if (j == 0) begin : g_head
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = rad;
    end else begin : g_body
      assign rem_i  = rem_q[j-1];
      assign root_i = root_q[j-1];
      assign rad_i  = rad_q[j-1];
    end

    // bring down the next two radicand bits, try root*4+1
    assign remx  = {rem_i[RW-1:0], rad_i[NW-1:NW-2]};
    assign trial = {root_i, 2'b01};
    assign ge    = remx >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j]  <= ge ? remx - trial : remx;
        root_q[j] <= {root_i[RW-2:0], ge};
        rad_q[j]  <= {rad_i[NW-3:0], 2'b00};
      end
    end
  end

  assign root = root_q[RW-1];

endmodule

@@ rtl/trsd_div.sv @@
// ----------------------------------------------------------------------------
// trsd_div
// Pipelined restoring divider, one quotient bit per stage. The caller
// guarantees num >> QW is below den, so QW stages give the full quotient.
// ----------------------------------------------------------------------------
module trsd_div #(
  parameter int NW = 62,
  parameter int DW = 32,
  parameter int QW = 31
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [DW-1:0] pr_q [QW];
  logic [QW-1:0] lo_q [QW];
  logic [DW-1:0] dn_q [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [DW-1:0] pr_i;
    logic [DW-1:0] dn_i;
    logic [QW-1:0] lo_i;
    logic [DW:0]   prx;
    logic          ge;

    if (j == 0) begin : g_head
      assign pr_i = DW'(num[NW-1:QW]);
      assign lo_i = num[QW-1:0];
      assign dn_i = den;
    end else begin : g_body
      assign pr_i = pr_q[j-1];
      assign lo_i = lo_q[j-1];
      assign dn_i = dn_q[j-1];
    end

    // quotient bits shift in at the low end as dividend bits leave the top
    assign prx = {pr_i, lo_i[QW-1]};
    assign ge  = prx >= {1'b0, dn_i};

    always_ff @(posedge clk) begin
      if (en) begin
        pr_q[j] <= ge ? DW'(prx - {1'b0, dn_i}) : DW'(prx);
        lo_q[j] <= {lo_i[QW-2:0], ge};
        dn_q[j] <= dn_i;
      end
    end
  end

  assign quo = lo_q[QW-1];

endmodule

@@ rtl/trsd_front.sv @@
// ----------------------------------------------------------------------------
// trsd_front
// Accepts matrices, measures column lengths and normalizes the columns
// into Q.30 rotation elements.
// ----------------------------------------------------------------------------
module trsd_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [383:0]         s_tdata,
  input  logic [15:0]          min_scale,
  output logic                 push,
  input  logic                 q_full,
  output trsd_pkg::trsd_item_t push_item
);

  import trsd_pkg::*;

  localparam int SqrtLat = 32;
  localparam int DivLat  = 31;
  localparam int Lat     = 2 + SqrtLat + 1 + DivLat + 1;
  localparam int Sh      = 30 - FRAC_BITS;
  localparam int SbW     = 9 + 9 * ElemW + 3 + 96 + 96;

  localparam logic signed [63:0] QSat = 64'sd2147483648;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  logic           en;
  logic [Lat-1:0] vld;

  assign en       = !vld[Lat-1] || !q_full;
  assign s_tready = en;
  assign push     = vld[Lat-1] && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Lat-2:0], s_tvalid};
    end
  end

  // squares and column sums
  logic signed [31:0] m  [9];
  logic [63:0]        sq [9];
  logic [63:0]        sum [3];
  logic [31:0]        len [3];

  for (genvar k = 0; k < 9; k++) begin : g_field
    assign m[k] = s_tdata[32*k +: 32];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        sq[k] <= 64'(mag32(m[k])) * 64'(mag32(m[k]));
      end
      for (int c = 0; c < 3; c++) begin
        sum[c] <= sq[3*c] + sq[3*c+1] + sq[3*c+2];
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_len
    trsd_isqrt #(.NW(64)) u_sqrt (
      .clk  (clk),
      .en   (en),
      .rad  (sum[c]),
      .root (len[c])
    );
  end

  logic [383:0] sd_a;

  trsd_pipe #(.W(384), .N(SqrtLat + 2)) u_sd_a (
    .clk (clk),
    .en  (en),
    .d   (s_tdata),
    .q   (sd_a)
  );

  // divide setup: numerator magnitude in Q.30, saturated fallback value
  logic signed [31:0] ma   [9];
  logic [61:0]        dnum [9];
  logic [31:0]        dden [3];
  logic [8:0]         dneg;
  elem_t [8:0]        dsat;
  logic [2:0]         ddiv;
  logic [2:0][31:0]   dlen;
  logic [2:0][31:0]   dtrans;

  for (genvar k = 0; k < 9; k++) begin : g_ma
    assign ma[k] = sd_a[32*k +: 32];
  end

  always_ff @(posedge clk) begin
    logic signed [63:0] w;
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        w = 64'(ma[k]) <<< Sh;
        if (w > QSat) begin
          w = QSat;
        end else if (w < -QSat) begin
          w = -QSat;
        end
        dsat[k] <= ElemW'(w);
        dneg[k] <= ma[k][31];
        dnum[k] <= {mag32(ma[k]), 30'b0};
      end
      for (int c = 0; c < 3; c++) begin
        dden[c]   <= len[c];
        dlen[c]   <= len[c];
        ddiv[c]   <= len[c] > {16'b0, min_scale};
        dtrans[c] <= sd_a[288 + 32*c +: 32];
      end
    end
  end

  logic [30:0] quo [9];

  for (genvar c = 0; c < 3; c++) begin : g_col
    for (genvar i = 0; i < 3; i++) begin : g_row
      trsd_div #(.NW(62), .DW(32), .QW(31)) u_div (
        .clk (clk),
        .en  (en),
        .num (dnum[3*c+i]),
        .den (dden[c]),
        .quo (quo[3*c+i])
      );
    end
  end

  logic [8:0]       bneg;
  elem_t [8:0]      bsat;
  logic [2:0]       bdiv;
  logic [2:0][31:0] blen;
  logic [2:0][31:0] btrans;
  logic [SbW-1:0]   sb_b;

  trsd_pipe #(.W(SbW), .N(DivLat)) u_sd_b (
    .clk (clk),
    .en  (en),
    .d   ({dneg, dsat, ddiv, dlen, dtrans}),
    .q   (sb_b)
  );

  assign {bneg, bsat, bdiv, blen, btrans} = sb_b;

  always_ff @(posedge clk) begin
    elem_t qv;
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        for (int i = 0; i < 3; i++) begin
          qv = elem_t'({2'b00, quo[3*c+i]});
          push_item.e[3*c+i] <= bdiv[c] ? (bneg[3*c+i] ? -qv : qv) : bsat[3*c+i];
        end
      end
      push_item.scale <= blen;
      push_item.trans <= btrans;
    end
  end

endmodule

@@ rtl/trsd_queue.sv @@
// ----------------------------------------------------------------------------
// trsd_queue
// Short queue between the normalizing front and the quaternion back.
// ----------------------------------------------------------------------------
module trsd_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  trsd_pkg::trsd_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 pop_valid,
  output trsd_pkg::trsd_item_t pop_item
);

  import trsd_pkg::*;

  localparam int AW = $clog2(QDepth);

  trsd_item_t    mem [QDepth];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full      = count == (AW+1)'(QDepth);
  assign pop_valid = count != '0;
  assign pop_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

@@ rtl/trsd_back.sv @@
// ----------------------------------------------------------------------------
// trsd_back
// Turns normalized rotation elements into a unit Q2.14 quaternion and
// drives the output register.
// ----------------------------------------------------------------------------
module trsd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  trsd_pkg::trsd_item_t in_item,
  output logic                 pop,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [255:0]         m_tdata
);

  import trsd_pkg::*;

  localparam int SqrtLat  = 32;
  localparam int QDivLat  = 62;
  localparam int NDivLat  = 15;
  localparam int ShiftLat = 6;
  localparam int Lat      = 2 + SqrtLat + 1 + QDivLat + 1 + 1 + ShiftLat + 2
                            + SqrtLat + 1 + NDivLat + 1;

  localparam logic signed [34:0] QOne = 35'sd1073741824;

  // greedy right-shift search: test against 2^31 after each trial shift
  localparam int Amt [ShiftLat] = '{16, 8, 4, 2, 1, 1};
  localparam int Thr [ShiftLat] = '{47, 39, 35, 33, 32, 31};

  function automatic logic [32:0] mag34(input logic signed [33:0] v);
    return v[33] ? 33'(-v) : 33'(v);
  endfunction

  logic           en;
  logic [Lat-1:0] vld;

  assign en       = !vld[Lat-1] || m_tready;
  assign pop      = in_valid && en;
  assign m_tvalid = vld[Lat-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[Lat-2:0], in_valid};
    end
  end

  // trace and diagonal compares
  elem_t              e1 [9];
  logic signed [34:0] tr1;
  logic               c04;
  logic               c08;
  logic               c48;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        e1[k] <= in_item.e[k];
      end
      tr1 <= 35'(elem_t'(in_item.e[0])) + 35'(elem_t'(in_item.e[4]))
             + 35'(elem_t'(in_item.e[8]));
      c04 <= elem_t'(in_item.e[0]) > elem_t'(in_item.e[4]);
      c08 <= elem_t'(in_item.e[0]) > elem_t'(in_item.e[8]);
      c48 <= elem_t'(in_item.e[4]) > elem_t'(in_item.e[8]);
    end
  end

  // branch: radicand, the three off-diagonal numerators, diagonal slot
  logic signed [33:0] x [9];
  logic signed [34:0] w [9];
  logic signed [34:0] rad_c;
  logic signed [33:0] n_c [3];
  logic [1:0]         dslot_c;

  for (genvar k = 0; k < 9; k++) begin : g_ext
    assign x[k] = 34'(e1[k]);
    assign w[k] = 35'(e1[k]);
  end

  always_comb begin
    if (tr1 > 0) begin
      rad_c   = tr1 + QOne;
      dslot_c = 2'd0;
      n_c[0]  = x[5] - x[7];
      n_c[1]  = x[6] - x[2];
      n_c[2]  = x[1] - x[3];
    end else if (c04 && c08) begin
      rad_c   = QOne + w[0] - w[4] - w[8];
      dslot_c = 2'd1;
      n_c[0]  = x[5] - x[7];
      n_c[1]  = x[3] + x[1];
      n_c[2]  = x[6] + x[2];
    end else if (c48) begin
      rad_c   = QOne + w[4] - w[0] - w[8];
      dslot_c = 2'd2;
      n_c[0]  = x[6] - x[2];
      n_c[1]  = x[3] + x[1];
      n_c[2]  = x[7] + x[5];
    end else begin
      rad_c   = QOne + w[8] - w[0] - w[4];
      dslot_c = 2'd3;
      n_c[0]  = x[1] - x[3];
      n_c[1]  = x[6] + x[2];
      n_c[2]  = x[7] + x[5];
    end
  end

  logic [63:0]              rad2;
  logic signed [2:0][33:0]  n2;
  logic [1:0]               dslot2;

  always_ff @(posedge clk) begin
    if (en) begin
      // clamp a negative radicand, move it to Q.60 for the root
      rad2   <= rad_c[34] ? '0 : {rad_c[33:0], 30'b0};
      dslot2 <= dslot_c;
      for (int t = 0; t < 3; t++) begin
        n2[t] <= n_c[t];
      end
    end
  end

  logic [31:0] root;

  trsd_isqrt #(.NW(64)) u_sqrt_s (
    .clk  (clk),
    .en   (en),
    .rad  (rad2),
    .root (root)
  );

  logic [2:0][33:0] na;
  logic [1:0]       dslota;

  trsd_pipe #(.W(104), .N(SqrtLat)) u_sd_a (
    .clk (clk),
    .en  (en),
    .d   ({n2, dslot2}),
    .q   ({na, dslota})
  );

  // quotient setup: s = 2*root, diagonal = s/4
  logic [62:0] qnum [3];
  logic [32:0] qden;
  logic [2:0]  pneg;
  logic        pzero;
  logic [30:0] pdiag;
  logic [1:0]  pslot;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int t = 0; t < 3; t++) begin
        qnum[t] <= {mag34(na[t]), 30'b0};
        pneg[t] <= na[t][33];
      end
      qden  <= {root, 1'b0};
      pzero <= root == '0;
      pdiag <= root[31:1];
      pslot <= dslota;
    end
  end

  logic [61:0] qquo [3];

  for (genvar t = 0; t < 3; t++) begin : g_qdiv
    trsd_div #(.NW(63), .DW(33), .QW(62)) u_div (
      .clk (clk),
      .en  (en),
      .num (qnum[t]),
      .den (qden),
      .quo (qquo[t])
    );
  end

  logic [2:0]  bneg;
  logic        bzero;
  logic [30:0] bdiag;
  logic [1:0]  bslot;

  trsd_pipe #(.W(37), .N(QDivLat)) u_sd_b (
    .clk (clk),
    .en  (en),
    .d   ({pneg, pzero, pdiag, pslot}),
    .q   ({bneg, bzero, bdiag, bslot})
  );

  // place components into quaternion slots as magnitude and sign
  logic [61:0] qm_c [4];
  logic [3:0]  qs_c;
  logic [61:0] qm   [4];
  logic [3:0]  qs;

  always_comb begin
    int t;
    for (int i = 0; i < 4; i++) begin
      t = (2'(i) > bslot) ? i - 1 : i;
      if (2'(i) == bslot) begin
        qm_c[i] = 62'(bdiag);
        qs_c[i] = 1'b0;
      end else begin
        qm_c[i] = bzero ? '0 : qquo[t[1:0]];
        qs_c[i] = !bzero && bneg[t[1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        qm[i] <= qm_c[i];
      end
      qs <= qs_c;
    end
  end

  // largest magnitude
  logic [61:0] mx01;
  logic [61:0] mx23;
  logic [61:0] mxm [4];
  logic [61:0] mx;
  logic [3:0]  mxs;

  assign mx01 = (qm[0] > qm[1]) ? qm[0] : qm[1];
  assign mx23 = (qm[2] > qm[3]) ? qm[2] : qm[3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        mxm[i] <= qm[i];
      end
      mx  <= (mx01 > mx23) ? mx01 : mx23;
      mxs <= qs;
    end
  end

  // scale all four down together until the largest is below 2^31
  logic [61:0] sh_m [ShiftLat][4];
  logic [61:0] sh_x [ShiftLat];
  logic [3:0]  sh_s [ShiftLat];

  for (genvar j = 0; j < ShiftLat; j++) begin : g_shift
    logic [61:0] m_i [4];
    logic [61:0] x_i;
    logic [3:0]  s_i;
    logic        g;

    if (j == 0) begin : g_head
      assign m_i = mxm;
      assign x_i = mx;
      assign s_i = mxs;
    end else begin : g_body
      assign m_i = sh_m[j-1];
      assign x_i = sh_x[j-1];
      assign s_i = sh_s[j-1];
    end

    assign g = (x_i >> Thr[j]) != '0;

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 4; i++) begin
          sh_m[j][i] <= g ? m_i[i] >> Amt[j] : m_i[i];
        end
        sh_x[j] <= g ? x_i >> Amt[j] : x_i;
        sh_s[j] <= s_i;
      end
    end
  end

  logic [3:0][30:0] mg;
  logic [61:0]      sqm [4];
  logic [63:0]      nsum;
  logic [31:0]      norm;

  for (genvar i = 0; i < 4; i++) begin : g_mg
    assign mg[i] = sh_m[ShiftLat-1][i][30:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        sqm[i] <= 62'(mg[i]) * 62'(mg[i]);
      end
      nsum <= 64'(sqm[0]) + 64'(sqm[1]) + 64'(sqm[2]) + 64'(sqm[3]);
    end
  end

  trsd_isqrt #(.NW(64)) u_sqrt_n (
    .clk  (clk),
    .en   (en),
    .rad  (nsum),
    .root (norm)
  );

  logic [3:0][30:0] cmg;
  logic [3:0]       cs;

  trsd_pipe #(.W(128), .N(2 + SqrtLat)) u_sd_c (
    .clk (clk),
    .en  (en),
    .d   ({sh_s[ShiftLat-1], mg}),
    .q   ({cs, cmg})
  );

  logic [44:0] nnum [4];
  logic [31:0] nden;
  logic [3:0]  ns;
  logic        nzero;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        nnum[i] <= {cmg[i], 14'b0};
      end
      nden  <= norm;
      ns    <= cs;
      nzero <= norm == '0;
    end
  end

  logic [14:0] nquo [4];

  for (genvar i = 0; i < 4; i++) begin : g_ndiv
    trsd_div #(.NW(45), .DW(32), .QW(15)) u_div (
      .clk (clk),
      .en  (en),
      .num (nnum[i]),
      .den (nden),
      .quo (nquo[i])
    );
  end

  logic [3:0]       ds;
  logic             dzero;
  logic [2:0][31:0] dscale;
  logic [2:0][31:0] dtrans;

  trsd_pipe #(.W(5), .N(NDivLat)) u_sd_d (
    .clk (clk),
    .en  (en),
    .d   ({ns, nzero}),
    .q   ({ds, dzero})
  );

  trsd_pipe #(.W(192), .N(Lat - 1)) u_sd_e (
    .clk (clk),
    .en  (en),
    .d   ({in_item.scale, in_item.trans}),
    .q   ({dscale, dtrans})
  );

  // output register
  logic [3:0][15:0] oq;
  logic [2:0][31:0] oscale;
  logic [2:0][31:0] otrans;

  always_ff @(posedge clk) begin
    logic [15:0] v;
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        v     = dzero ? '0 : 16'(nquo[i]);
        oq[i] <= ds[i] ? 16'(-v) : v;
      end
      oscale <= dscale;
      otrans <= dtrans;
    end
  end

  assign m_tdata = {oscale, oq, otrans};

endmodule

@@ rtl/trs_matrix_decomposition.sv @@
// ----------------------------------------------------------------------------
// trs_matrix_decomposition
// Splits an affine transform into translation, rotation quaternion and scale.
// ----------------------------------------------------------------------------
// Takes one matrix per clock and returns one result per clock when the output
// is not stalled. Each matrix passes through the front (column lengths and
// normalization), the four-entry queue and the back (quaternion and its
// normalization); the latency is set by the bit-per-stage square root and
// divider pipelines. The translation passes through; scales are the floored
// column lengths; the quaternion is Q2.14. Write min_scale only while no item
// is in flight.
module trs_matrix_decomposition #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // col0_x, col0_y, col0_z, col1_x, col1_y, col1_z, col2_x, col2_y, col2_z,
  // in_trans_x, in_trans_y, in_trans_z (32 bits each)
  input  logic [383:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_trans_x, out_trans_y, out_trans_z (32), quat_w, quat_x, quat_y,
  // quat_z (16), scale_x, scale_y, scale_z (32)
  output logic [255:0] m_tdata,
  input  logic         cfg_wen,
  input  logic [15:0]  cfg_wdata
);

  import trsd_pkg::*;

  logic [15:0] min_scale;
  logic        push;
  logic        q_full;
  logic        pop;
  logic        pop_valid;
  trsd_item_t  push_item;
  trsd_item_t  pop_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_scale <= '0;
    end else if (cfg_wen) begin
      min_scale <= cfg_wdata;
    end
  end

  trsd_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .min_scale (min_scale),
    .push      (push),
    .q_full    (q_full),
    .push_item (push_item)
  );

  trsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_item  (pop_item)
  );

  trsd_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pop_valid),
    .in_item  (pop_item),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
